/* rtl/core/vaft_pkg.sv */
// vaft_pkg: shared widths, payload types and the arctangent table for the
// vector angle pipeline. No dependencies; every rtl/core file imports it.
package vaft_pkg;

   // field widths fixed by the payload format
   localparam int COORD_BITS = 24;
   localparam int ANGLE_BITS = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   // derived datapath widths
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int DOT_BITS  = PROD_BITS + 1;
   localparam int MAG_BITS  = 2 * COORD_BITS + 1;
   localparam int NORM_BITS = (MAG_BITS < 60) ? MAG_BITS : 60;
   localparam int XY_BITS   = NORM_BITS + 2;
   localparam int Z_BITS    = 34;
   localparam int TURN_BITS = 32;

   // turn constants in 2^-32 units
   localparam logic [TURN_BITS-1:0] TURN_HALF    = 32'h8000_0000;
   localparam logic [TURN_BITS-1:0] TURN_QUARTER = 32'h4000_0000;
   localparam logic [TURN_BITS-1:0] TURN_3QUART  = 32'hC000_0000;
   localparam logic signed [Z_BITS-1:0] Z_LIMIT  = 34'sh0_4000_0000;

   // output rounding
   localparam int RND_SHIFT = TURN_BITS - ANGLE_BITS;
   localparam logic [TURN_BITS:0] RND_HALF =
      (RND_SHIFT > 0) ? ((TURN_BITS+1)'(1) << (RND_SHIFT - 1)) : '0;

   // round(atan(2^-i) / (2*pi) * 2^32)
   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef struct packed {
      logic signed [COORD_BITS-1:0] first_x;
      logic signed [COORD_BITS-1:0] first_y;
      logic signed [COORD_BITS-1:0] center_x;
      logic signed [COORD_BITS-1:0] center_y;
      logic signed [COORD_BITS-1:0] second_x;
      logic signed [COORD_BITS-1:0] second_y;
   } req_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] angle_turns;
      logic                  degenerate;
   } rsp_type;

   // per-item flags that ride alongside the CORDIC
   typedef struct packed {
      logic degenerate;
      logic crs_zero;
      logic dot_zero;
      logic dneg;
      logic cneg;
   } side_type;

   typedef struct packed {
      side_type             side;
      logic [NORM_BITS-1:0] mx;
      logic [NORM_BITS-1:0] my;
   } norm_type;

endpackage

/* rtl/core/vaft_prep.sv */
// vaft_prep: differences, products, dot/cross, magnitudes and normalization
// in five register stages. Depends on vaft_pkg.
module vaft_prep (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  vaft_pkg::req_type  in_req,
   output logic               out_valid,
   output vaft_pkg::norm_type out_norm
);
   import vaft_pkg::*;

   localparam int KW = $clog2(MAG_BITS + 1);

   logic                        v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [DIFF_BITS-1:0] ux_ff, uy_ff, vx_ff, vy_ff;
   logic signed [PROD_BITS-1:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic                        degen2_ff, degen3_ff;
   logic signed [DOT_BITS-1:0]  dot_ff, crs_ff;
   side_type                    side4_ff;
   logic [MAG_BITS-1:0]         md_ff, mc_ff;
   logic [MAG_BITS-1:0]         mor_in;
   logic [KW-1:0]               k_in;
   norm_type                    norm_ff;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // stage 1: vectors from the center, one bit wider
   always_ff @(posedge clock) begin
      ux_ff <= DIFF_BITS'(in_req.first_x)  - DIFF_BITS'(in_req.center_x);
      uy_ff <= DIFF_BITS'(in_req.first_y)  - DIFF_BITS'(in_req.center_y);
      vx_ff <= DIFF_BITS'(in_req.second_x) - DIFF_BITS'(in_req.center_x);
      vy_ff <= DIFF_BITS'(in_req.second_y) - DIFF_BITS'(in_req.center_y);
   end

   // stage 2: four exact products, zero-length check
   always_ff @(posedge clock) begin
      pa_ff     <= PROD_BITS'(ux_ff) * PROD_BITS'(vx_ff);
      pb_ff     <= PROD_BITS'(uy_ff) * PROD_BITS'(vy_ff);
      pc_ff     <= PROD_BITS'(ux_ff) * PROD_BITS'(vy_ff);
      pd_ff     <= PROD_BITS'(uy_ff) * PROD_BITS'(vx_ff);
      degen2_ff <= (ux_ff == '0 && uy_ff == '0) || (vx_ff == '0 && vy_ff == '0);
   end

   // stage 3: dot and cross
   always_ff @(posedge clock) begin
      dot_ff    <= DOT_BITS'(pa_ff) + DOT_BITS'(pb_ff);
      crs_ff    <= DOT_BITS'(pc_ff) - DOT_BITS'(pd_ff);
      degen3_ff <= degen2_ff;
   end

   // stage 4: signs, zero flags, magnitudes
   always_ff @(posedge clock) begin
      side4_ff.degenerate <= degen3_ff;
      side4_ff.crs_zero   <= (crs_ff == '0);
      side4_ff.dot_zero   <= (dot_ff == '0);
      side4_ff.dneg       <= dot_ff[DOT_BITS-1];
      side4_ff.cneg       <= crs_ff[DOT_BITS-1];
      md_ff <= MAG_BITS'(dot_ff[DOT_BITS-1] ? -dot_ff : dot_ff);
      mc_ff <= MAG_BITS'(crs_ff[DOT_BITS-1] ? -crs_ff : crs_ff);
   end

   // stage 5: common right shift until both fit the CORDIC width
   always_comb begin
      mor_in = md_ff | mc_ff;
      k_in   = '0;
      for (int j = NORM_BITS; j < MAG_BITS; j++) begin
         if (mor_in[j]) k_in = KW'(j - NORM_BITS + 1);
      end
   end

   always_ff @(posedge clock) begin
      norm_ff.side <= side4_ff;
      norm_ff.mx   <= NORM_BITS'(md_ff >> k_in);
      norm_ff.my   <= NORM_BITS'(mc_ff >> k_in);
   end

   assign out_valid = v5_ff;
   assign out_norm  = norm_ff;

endmodule

/* rtl/core/vaft_cordic.sv */
// vaft_cordic: vectoring CORDIC, one micro-rotation per register stage,
// angle accumulated in 2^-32 turn units. Depends on vaft_pkg.
module vaft_cordic #(
   parameter int STAGES = vaft_pkg::CORDIC_STAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  vaft_pkg::norm_type                in_norm,
   output logic                              out_valid,
   output vaft_pkg::side_type                out_side,
   output logic signed [vaft_pkg::Z_BITS-1:0] out_z
);
   import vaft_pkg::*;

   logic signed [XY_BITS-1:0] x_ff    [STAGES-1];
   logic signed [XY_BITS-1:0] y_ff    [STAGES-1];
   logic signed [Z_BITS-1:0]  z_ff    [STAGES];
   side_type                  side_ff [STAGES];
   logic                      v_ff    [STAGES];

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      localparam logic signed [Z_BITS-1:0] STEP = Z_BITS'(ATAN_TURNS[g]);

      logic signed [XY_BITS-1:0] y_cur;
      logic signed [Z_BITS-1:0]  z_cur;
      side_type                  side_cur;
      logic                      v_cur;
      logic signed [Z_BITS-1:0]  z_in;

      // stage inputs: normalized magnitudes or the previous stage
      if (g == 0) begin : g_head
         assign y_cur    = signed'({2'b00, in_norm.my});
         assign z_cur    = '0;
         assign side_cur = in_norm.side;
         assign v_cur    = in_valid;
      end else begin : g_body
         assign y_cur    = y_ff[g-1];
         assign z_cur    = z_ff[g-1];
         assign side_cur = side_ff[g-1];
         assign v_cur    = v_ff[g-1];
      end

      // rotate toward the x axis: sign of y picks the direction
      assign z_in = y_cur[XY_BITS-1] ? (z_cur - STEP) : (z_cur + STEP);

      always_ff @(posedge clock) begin
         if (reset) v_ff[g] <= 1'b0;
         else       v_ff[g] <= v_cur;
      end

      always_ff @(posedge clock) begin
         z_ff[g]    <= z_in;
         side_ff[g] <= side_cur;
      end

      // x and y are not needed after the last rotation
      if (g < STAGES - 1) begin : g_rot
         logic signed [XY_BITS-1:0] x_cur;
         logic signed [XY_BITS-1:0] xs, ys;

         if (g == 0) begin : g_x0
            assign x_cur = signed'({2'b00, in_norm.mx});
         end else begin : g_xn
            assign x_cur = x_ff[g-1];
         end

         assign xs = x_cur >>> g;
         assign ys = y_cur >>> g;

         always_ff @(posedge clock) begin
            if (y_cur[XY_BITS-1]) begin
               x_ff[g] <= x_cur - ys;
               y_ff[g] <= y_cur + xs;
            end else begin
               x_ff[g] <= x_cur + ys;
               y_ff[g] <= y_cur - xs;
            end
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];
   assign out_z     = z_ff[STAGES-1];

endmodule

/* rtl/core/vaft_post.sv */
// vaft_post: clamp, quadrant restore, special cases and rounding to the
// output angle width, two register stages. Depends on vaft_pkg.
module vaft_post (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  vaft_pkg::side_type                in_side,
   input  logic signed [vaft_pkg::Z_BITS-1:0] in_z,
   output logic                              out_strobe,
   output vaft_pkg::rsp_type                 out_rsp
);
   import vaft_pkg::*;

   logic                 v1_ff, v2_ff;
   logic [TURN_BITS-1:0] th_in, t_in, t_ff;
   logic                 degen_ff;
   logic [TURN_BITS:0]   sum_in;
   rsp_type              rsp_ff;

   // clamp first-quadrant angle, then place it in its quadrant
   always_comb begin
      if (in_z[Z_BITS-1])    th_in = '0;
      else if (in_z > Z_LIMIT) th_in = TURN_QUARTER;
      else                   th_in = TURN_BITS'(in_z);

      if (in_side.degenerate)    t_in = '0;
      else if (in_side.crs_zero) t_in = in_side.dneg ? TURN_HALF : '0;
      else if (in_side.dot_zero) t_in = in_side.cneg ? TURN_3QUART : TURN_QUARTER;
      else begin
         case ({in_side.dneg, in_side.cneg})
            2'b00:   t_in = th_in;
            2'b10:   t_in = TURN_HALF - th_in;
            2'b11:   t_in = TURN_HALF + th_in;
            default: t_in = '0 - th_in;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      t_ff     <= t_in;
      degen_ff <= in_side.degenerate;
   end

   // round half up; a full turn wraps to zero
   assign sum_in = {1'b0, t_ff} + RND_HALF;

   always_ff @(posedge clock) begin
      rsp_ff.angle_turns <= sum_in[RND_SHIFT +: ANGLE_BITS];
      rsp_ff.degenerate  <= degen_ff;
   end

   assign out_strobe = v2_ff;
   assign out_rsp    = rsp_ff;

endmodule

/* rtl/core/vector_angle_full_turn.sv */
// vector_angle_full_turn: counter-clockwise angle from (first - center) to
// (second - center) as a fraction of a full turn, via a pipelined CORDIC.
// Throughput: one transfer per cycle outside reset; set by the one-rotation-per-stage CORDIC.
// Reset: synchronous; clears all valid bits; busy is high only during reset.
// The receiver cannot stall, so results leave on rsp_strobe unconditionally.
module vector_angle_full_turn #(
   parameter int CORDIC_STAGES = vaft_pkg::CORDIC_STAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vaft_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output vaft_pkg::rsp_type rsp_payload
);
   import vaft_pkg::*;

   localparam int LATENCY = CORDIC_STAGES + 7;

   logic     req_take;
   logic     norm_valid, cordic_valid;
   norm_type norm;
   side_type cordic_side;
   logic signed [Z_BITS-1:0] cordic_z;

   // no backpressure anywhere: a transfer is taken whenever not in reset
   assign busy     = reset;
   assign req_take = start & ~busy;

   vaft_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_take),
      .in_req    (req_payload),
      .out_valid (norm_valid),
      .out_norm  (norm)
   );

   vaft_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_norm   (norm),
      .out_valid (cordic_valid),
      .out_side  (cordic_side),
      .out_z     (cordic_z)
   );

   vaft_post u_post (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (cordic_valid),
      .in_side    (cordic_side),
      .in_z       (cordic_z),
      .out_strobe (rsp_strobe),
      .out_rsp    (rsp_payload)
   );

   // every result traces back to a taken transfer through the prep, CORDIC and post stages
   a_rsp_has_req : assert property (@(posedge clock)
      rsp_strobe |-> $past(req_take, LATENCY))
      else $error("result without matching request");

   // a degenerate result carries a zero angle
   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.degenerate |-> rsp_payload.angle_turns == '0)
      else $error("degenerate result with nonzero angle");

   // first point on the center must come out degenerate
   a_degen_first : assert property (@(posedge clock)
      rsp_strobe && $past(req_take && req_payload.first_x == req_payload.center_x
                          && req_payload.first_y == req_payload.center_y, LATENCY)
      |-> rsp_payload.degenerate)
      else $error("zero-length first vector not flagged");

endmodule
